>>> hw/rtl/sfd_pkg.sv
// shared types and constants of the sensor frame deframer
package sfd_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int IDX_W  = 4;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd147;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd224;

    // commands from the controller, each already qualified by its handshake
    typedef struct packed {
        logic hunt;       // restart sums and byte count
        logic take_id;
        logic take_len;
        logic take_pay;
        logic take_cklo;
        logic take_ckhi;  // clears the word counter
        logic rd;         // read one word from the payload store
        logic load;       // move read data into the output register
    } sfd_cmd_t;

    // status from the datapath
    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic len_zero;
        logic count_done;
        logic check_ok;
        logic out_free;
        logic last;
    } sfd_stat_t;

endpackage

>>> hw/rtl/sfd_ifs.sv
// valid/ready channel interfaces for received bytes and decoded words
interface sfd_byte_if;
    import sfd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_word_if;
    import sfd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_kind;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_value;
    logic              last_word;

    modport source (output valid, output frame_kind, output word_index,
                    output word_value, output last_word, input ready);
    modport sink (input valid, input frame_kind, input word_index,
                  input word_value, input last_word, output ready);
endinterface

>>> hw/rtl/sfd_ctrl.sv
// frame parsing controller: phase state machine and word emission sequencing
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sfd_stat_t stat,
    output sfd_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_HUNT    = 9'b000000001,
        ST_SYNC2   = 9'b000000010,
        ST_ID      = 9'b000000100,
        ST_LEN     = 9'b000001000,
        ST_PAY     = 9'b000010000,
        ST_CKLO    = 9'b000100000,
        ST_CKHI    = 9'b001000000,
        ST_EMIT_RD = 9'b010000000,
        ST_EMIT_LD = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   acc;

    // input is held off only while a frame's words go out
    assign in_ready = (state_reg != ST_EMIT_RD) && (state_reg != ST_EMIT_LD);
    assign acc      = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_SYNC2:
            begin
                if (acc)
                begin
                    if (stat.is_sync2)
                    begin
                        state_next = ST_ID;
                    end
                    else if (!stat.is_sync1)
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_ID:
            begin
                if (acc)
                begin
                    cmd.take_id = 1'b1;
                    state_next  = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (acc)
                begin
                    cmd.take_len = 1'b1;
                    state_next   = stat.len_zero ? ST_CKLO : ST_PAY;
                end
            end
            ST_PAY:
            begin
                if (acc)
                begin
                    cmd.take_pay = 1'b1;
                    if (stat.count_done)
                    begin
                        state_next = ST_CKLO;
                    end
                end
            end
            ST_CKLO:
            begin
                if (acc)
                begin
                    cmd.take_cklo = 1'b1;
                    state_next    = ST_CKHI;
                end
            end
            ST_CKHI:
            begin
                if (acc)
                begin
                    cmd.take_ckhi = 1'b1;
                    state_next    = stat.check_ok ? ST_EMIT_RD : ST_HUNT;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.last ? ST_HUNT : ST_EMIT_RD;
                end
            end
            default:
            begin
                // hunting, also the landing place for any stray encoding
                if (acc)
                begin
                    cmd.hunt   = 1'b1;
                    state_next = stat.is_sync1 ? ST_SYNC2 : ST_HUNT;
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/sfd_dp.sv
// frame parsing datapath: sync registers, checksums, payload store, output register
module sfd_dp
    import sfd_pkg::*;
#(
    parameter int POT_WORDS    = 10,
    parameter int ANALOG_WORDS = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  sfd_cmd_t             cmd,
    output sfd_stat_t            stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [BYTE_W-1:0]    frame_kind,
    output logic [IDX_W-1:0]     word_index,
    output logic [WORD_W-1:0]    word_value,
    output logic                 last_word
);

    localparam int TOTAL_WORDS = POT_WORDS + ANALOG_WORDS;
    localparam int STORE_BYTES = 2 * TOTAL_WORDS;
    localparam int DEPTH       = (TOTAL_WORDS > 0) ? TOTAL_WORDS : 1;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW          = $clog2(DEPTH + 1);

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [BYTE_W-1:0] frame_id_reg;
    logic [BYTE_W-1:0] frame_len_reg;
    logic [BYTE_W-1:0] byte_count_reg;
    logic [BYTE_W-1:0] sum_a_reg;
    logic [BYTE_W-1:0] sum_b_reg;
    logic [BYTE_W-1:0] check_low_reg;
    logic [BYTE_W-1:0] sum_a_next;
    logic [BYTE_W-1:0] sum_b_next;
    logic [CW-1:0]     word_cnt_reg;

    logic [BYTE_W-1:0] mem_lo [DEPTH];
    logic [BYTE_W-1:0] mem_hi [DEPTH];
    logic [DEPTH-1:0]  lo_vld_reg;
    logic [DEPTH-1:0]  hi_vld_reg;
    logic [BYTE_W-1:0] rd_lo_reg;
    logic [BYTE_W-1:0] rd_hi_reg;
    logic              rd_lo_vld_reg;
    logic              rd_hi_vld_reg;

    logic              store_en;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [CW+IDX_W-1:0] idx_ext;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] frame_kind_reg;
    logic [IDX_W-1:0]  word_index_reg;
    logic [WORD_W-1:0] word_value_reg;
    logic              last_word_reg;

    // running sums over id, length and payload
    assign sum_a_next = sum_a_reg + rx_byte;
    assign sum_b_next = sum_b_reg + sum_a_next;

    assign store_en = ({1'b0, byte_count_reg} < (BYTE_W + 1)'(STORE_BYTES));
    assign waddr    = byte_count_reg[AW:1];
    assign raddr    = word_cnt_reg[AW-1:0];
    assign idx_ext  = {{IDX_W{1'b0}}, word_cnt_reg};

    // status to the controller
    always_comb
    begin
        stat.is_sync1   = (rx_byte == sync_first_reg);
        stat.is_sync2   = (rx_byte == sync_second_reg);
        stat.len_zero   = (rx_byte == '0);
        stat.count_done = (({1'b0, byte_count_reg} + 9'd1) >= {1'b0, frame_len_reg});
        stat.check_ok   = (TOTAL_WORDS > 0) && (sum_a_reg == check_low_reg)
                          && (sum_b_reg == rx_byte);
        stat.out_free   = !out_valid_reg || out_ready;
        stat.last       = (word_cnt_reg == CW'(TOTAL_WORDS - 1));
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SYNC_FIRST)
            begin
                sync_first_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_SYNC_SECOND)
            begin
                sync_second_reg <= cfg_wdata;
            end
        end
    end

    // frame header, count and checksum registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            word_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.hunt)
            begin
                byte_count_reg <= '0;
                sum_a_reg      <= '0;
                sum_b_reg      <= '0;
            end
            if (cmd.take_id || cmd.take_len || cmd.take_pay)
            begin
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
            end
            if (cmd.take_pay)
            begin
                byte_count_reg <= byte_count_reg + 8'd1;
            end
            if (cmd.take_ckhi)
            begin
                word_cnt_reg <= '0;
            end
            else if (cmd.load)
            begin
                word_cnt_reg <= word_cnt_reg + 1'b1;
            end
        end
    end

    // header payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_id)
        begin
            frame_id_reg <= rx_byte;
        end
        if (cmd.take_len)
        begin
            frame_len_reg <= rx_byte;
        end
        if (cmd.take_cklo)
        begin
            check_low_reg <= rx_byte;
        end
    end

    // payload store, split into low and high byte of each word
    always_ff @(posedge clk)
    begin
        if (cmd.take_pay && store_en)
        begin
            if (byte_count_reg[0])
            begin
                mem_hi[waddr] <= rx_byte;
            end
            else
            begin
                mem_lo[waddr] <= rx_byte;
            end
        end
        if (cmd.rd)
        begin
            rd_lo_reg <= mem_lo[raddr];
            rd_hi_reg <= mem_hi[raddr];
        end
    end

    // written marks: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_vld_reg    <= '0;
            hi_vld_reg    <= '0;
            rd_lo_vld_reg <= 1'b0;
            rd_hi_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_pay && store_en)
            begin
                if (byte_count_reg[0])
                begin
                    hi_vld_reg[waddr] <= 1'b1;
                end
                else
                begin
                    lo_vld_reg[waddr] <= 1'b1;
                end
            end
            if (cmd.rd)
            begin
                rd_lo_vld_reg <= lo_vld_reg[raddr];
                rd_hi_vld_reg <= hi_vld_reg[raddr];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_kind_reg <= frame_id_reg;
            word_index_reg <= idx_ext[IDX_W-1:0];
            word_value_reg <= {(rd_hi_vld_reg ? rd_hi_reg : 8'd0),
                               (rd_lo_vld_reg ? rd_lo_reg : 8'd0)};
            last_word_reg  <= stat.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_kind = frame_kind_reg;
    assign word_index = word_index_reg;
    assign word_value = word_value_reg;
    assign last_word  = last_word_reg;

endmodule

>>> hw/rtl/sensor_frame_deframer_core.sv
// top level of the sensor frame deframer
// Takes received serial bytes, finds the two sync bytes (a repeated first sync byte keeps
// waiting), then reads id, length, payload and low/high check bytes, with two 8-bit
// Fletcher-style sums over id, length and payload. On a match the block sends
// POT_WORDS + ANALOG_WORDS little-endian 16-bit words built from the first payload bytes,
// pot words first; bytes beyond the store are summed only, and a short frame sends older
// stored bytes (zero after reset). A good frame then holds the byte input off while its
// words go out, including any output stall: each word needs a read of the single-port
// payload store with registered read data, then a load of the output register. The last
// word may still wait at the output while the next bytes come in. No clearing pass after
// reset: per-entry written marks cover the store.
module sensor_frame_deframer_core
    import sfd_pkg::*;
#(
    parameter int POT_WORDS    = 10,
    parameter int ANALOG_WORDS = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    sfd_byte_if.sink             in_ch,
    sfd_word_if.source           out_ch
);

    sfd_cmd_t  cmd;
    sfd_stat_t stat;

    // phase controller
    sfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    sfd_dp #(
        .POT_WORDS    (POT_WORDS),
        .ANALOG_WORDS (ANALOG_WORDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .rx_byte    (in_ch.rx_byte),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .frame_kind (out_ch.frame_kind),
        .word_index (out_ch.word_index),
        .word_value (out_ch.word_value),
        .last_word  (out_ch.last_word)
    );

endmodule
